FILE: src/rrc_pkg.sv
package rrc_pkg;

  // window and derived index widths
  localparam int WINDOW = 90;
  localparam int PTR_W  = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);

  // fixed point formats
  localparam int RET_W  = 24;
  localparam int Q_FRAC = 22;
  localparam logic signed [RET_W-1:0] RET_MAX = 24'sh7fffff;
  localparam logic signed [RET_W-1:0] RET_MIN = 24'sh800000;
  localparam logic [63:0] RET_MAG_POS = 64'd8388607;
  localparam logic [63:0] RET_MAG_NEG = 64'd8388608;
  localparam logic signed [23:0] Q_ONE = 24'sd4194304;

  // serial unit step counts
  localparam logic [6:0] DIV_STEPS = 7'd64;
  localparam logic [6:0] MUL_STEPS = 7'd64;
  localparam logic [6:0] SQRT_STEPS = 7'd64;

  // configuration register indexes
  localparam int IDX_W = 1;
  localparam logic [IDX_W-1:0] REG_MODE  = 1'b0;
  localparam logic [IDX_W-1:0] REG_METAL = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOT_FULL = 2'd1;
  localparam logic [1:0] ST_ZERO_VAR = 2'd2;
  localparam logic [1:0] ST_DISABLED = 2'd3;

  // request to the serial divider
  typedef struct packed {
    logic [63:0] init_rem;
    logic [63:0] dividend;
    logic [63:0] divisor;
    logic [6:0]  steps;
  } div_req_t;

endpackage

FILE: src/rrc_ram.sv
module rrc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 90
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/rrc_div.sv
module rrc_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  rrc_pkg::div_req_t req,
  output logic              done,
  output logic [63:0]       quotient
);
  import rrc_pkg::*;

  logic [63:0] rem;
  logic [63:0] dvd;
  logic [63:0] dsr;
  logic [63:0] quo;
  logic [6:0]  cnt;
  logic        busy;
  logic [64:0] shifted;
  logic [64:0] diff;

  // restoring step, one quotient bit per cycle
  assign shifted  = {rem, dvd[63]};
  assign diff     = shifted - {1'b0, dsr};
  assign quotient = quo;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= req.init_rem;
      dvd <= req.dividend;
      dsr <= req.divisor;
      quo <= '0;
    end else if (busy) begin
      if (!diff[64]) begin
        rem <= diff[63:0];
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= shifted[63:0];
        quo <= {quo[62:0], 1'b0};
      end
      dvd <= {dvd[62:0], 1'b0};
    end
  end

endmodule

FILE: src/rrc_mul.sv
module rrc_mul (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic         done,
  output logic [127:0] product
);
  import rrc_pkg::*;

  logic [127:0] acc;
  logic [127:0] mc;
  logic [63:0]  mr;
  logic [6:0]   cnt;
  logic         busy;

  assign product = acc;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= MUL_STEPS;
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift and add, one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      mc  <= {64'd0, a};
      mr  <= b;
    end else if (busy) begin
      if (mr[0]) begin
        acc <= acc + mc;
      end
      mc <= {mc[126:0], 1'b0};
      mr <= {1'b0, mr[63:1]};
    end
  end

endmodule

FILE: src/rrc_sqrt.sv
module rrc_sqrt (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [127:0] radicand,
  output logic         done,
  output logic [63:0]  root
);
  import rrc_pkg::*;

  logic [127:0] rad;
  logic [65:0]  rem;
  logic [63:0]  res;
  logic [6:0]   cnt;
  logic         busy;
  logic [67:0]  sh;
  logic [67:0]  trial;
  logic [67:0]  diff;

  // digit by digit root, two radicand bits per cycle
  assign sh    = {rem, rad[127:126]};
  assign trial = {2'b00, res, 2'b01};
  assign diff  = sh - trial;
  assign root  = res;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= SQRT_STEPS;
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rad <= radicand;
      rem <= '0;
      res <= '0;
    end else if (busy) begin
      if (sh >= trial) begin
        rem <= diff[65:0];
        res <= {res[62:0], 1'b1};
      end else begin
        rem <= sh[65:0];
        res <= {res[62:0], 1'b0};
      end
      rad <= {rad[125:0], 2'b00};
    end
  end

endmodule

FILE: src/rolling_return_correlation_top.sv
// Rolling Pearson correlation of asset returns against a reference series over the
// last 90 valid pairs. Each transfer in gives exactly one transfer out. An item that
// forms no pair skips the return steps; one that forms a pair runs the serial
// price-return divide, in relative mode a relative reference divide, then a ring
// read, six multiply-accumulate steps and a write. Once the window is full and the
// output is not disabled, the variance terms, the serial product and the square root
// follow, then the final divide when the root is nonzero and exceeds the numerator.
// The bit-serial divider, multiplier and root unit produce one bit or one root digit
// per cycle. The pair ring is a 90-entry memory whose contents are undefined until
// written; its read data is used only once the window is full, so no clearing pass
// runs after reset. Configuration writes take effect at once and are to be made while
// the block is idle.
module rolling_return_correlation_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [rrc_pkg::IDX_W-1:0] cfg_index,
  input  logic [0:0]                cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [31:0]               price,
  input  logic [22:0]               ref_value,
  input  logic                      first_sample,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [23:0]        correlation,
  output logic [1:0]                status
);
  import rrc_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_XSTART = 5'd1;
  localparam logic [4:0] S_XWAIT  = 5'd2;
  localparam logic [4:0] S_YSTART = 5'd3;
  localparam logic [4:0] S_YWAIT  = 5'd4;
  localparam logic [4:0] S_RD     = 5'd5;
  localparam logic [4:0] S_RDW    = 5'd6;
  localparam logic [4:0] S_MAC    = 5'd7;
  localparam logic [4:0] S_WR     = 5'd8;
  localparam logic [4:0] S_STATS  = 5'd9;
  localparam logic [4:0] S_VAR    = 5'd10;
  localparam logic [4:0] S_MSTART = 5'd11;
  localparam logic [4:0] S_MWAIT  = 5'd12;
  localparam logic [4:0] S_QSTART = 5'd13;
  localparam logic [4:0] S_QWAIT  = 5'd14;
  localparam logic [4:0] S_DSTART = 5'd15;
  localparam logic [4:0] S_DWAIT  = 5'd16;
  localparam logic [4:0] S_OUT    = 5'd17;

  logic [4:0]              state;
  logic                    reference_mode;
  logic                    is_metal;
  logic [31:0]             previous_price;
  logic [22:0]             previous_ref;
  logic                    have_previous;
  logic [PTR_W-1:0]        ring_pointer;
  logic [CNT_W-1:0]        valid_count;
  logic signed [30:0]      sum_returns;
  logic signed [30:0]      sum_changes;
  logic signed [54:0]      sum_cross;
  logic signed [54:0]      sum_returns_sq;
  logic signed [54:0]      sum_changes_sq;
  logic [31:0]             cur_price;
  logic [22:0]             cur_ref;
  logic signed [RET_W-1:0] ret_x;
  logic signed [RET_W-1:0] ret_y;
  logic signed [RET_W-1:0] old_x;
  logic signed [RET_W-1:0] old_y;
  logic [2:0]              mstep;
  logic [1:0]              vstep;
  logic signed [47:0]      prod48;
  logic signed [63:0]      vprod;
  logic signed [63:0]      vnm;
  logic signed [63:0]      num_v;
  logic signed [63:0]      vx;
  logic signed [63:0]      vy;
  logic [63:0]             root_d;
  logic signed [23:0]      corr_r;
  logic [1:0]              status_r;

  logic                    window_full;
  logic                    pair;
  logic                    sel_y;
  logic [31:0]             now32;
  logic [31:0]             before32;
  logic [32:0]             rdiff;
  logic                    rneg;
  logic [31:0]             rabs;
  logic signed [23:0]      ydiff;
  logic [63:0]             num_mag;
  logic signed [RET_W-1:0] ma;
  logic signed [RET_W-1:0] mb;
  logic signed [54:0]      vs;
  logic signed [31:0]      sa;
  logic signed [31:0]      sb;
  logic signed [63:0]      vs_ext;
  logic signed [54:0]      prod_ext;

  logic                    div_start;
  div_req_t                div_req;
  logic                    div_done;
  logic [63:0]             div_q;
  logic                    mul_start;
  logic [63:0]             mul_a;
  logic [63:0]             mul_b;
  logic                    mul_done;
  logic [127:0]            mul_p;
  logic                    sq_start;
  logic                    sq_done;
  logic [63:0]             sq_root;
  logic                    ram_we;
  logic                    ram_re;
  logic [2*RET_W-1:0]      ram_rdata;

  // saturate a return magnitude with its sign to Q2.22
  function automatic logic signed [RET_W-1:0] sat_ret(input logic [63:0] q, input logic neg);
    logic signed [RET_W-1:0] r;
    if (neg) begin
      r = (q > RET_MAG_NEG) ? RET_MIN : $signed(-q[RET_W-1:0]);
    end else begin
      r = (q > RET_MAG_POS) ? RET_MAX : $signed(q[RET_W-1:0]);
    end
    return r;
  endfunction

  // apply numerator sign and metal flag
  function automatic logic signed [23:0] apply_sign(input logic signed [23:0] q,
                                                    input logic neg, input logic flip);
    logic signed [23:0] s;
    s = neg ? -q : q;
    return flip ? -s : s;
  endfunction

  assign in_ready    = (state == S_IDLE);
  assign window_full = (valid_count == CNT_W'(WINDOW));
  assign pair        = !first_sample && have_previous &&
                       (previous_price != 32'd0) && (previous_ref != 23'd0);

  // return operands for the divider
  always_comb begin
    sel_y    = (state == S_YSTART) || (state == S_YWAIT);
    now32    = sel_y ? {9'd0, cur_ref} : cur_price;
    before32 = sel_y ? {9'd0, previous_ref} : previous_price;
    rdiff    = {1'b0, now32} - {1'b0, before32};
    rneg     = rdiff[32];
    rabs     = rneg ? 32'(-rdiff) : rdiff[31:0];
    ydiff    = $signed({1'b0, cur_ref}) - $signed({1'b0, previous_ref});
    num_mag  = num_v[63] ? 64'(-num_v) : 64'(num_v);
  end

  // divider request
  always_comb begin
    div_start = (state == S_XSTART) || (state == S_YSTART) || (state == S_DSTART);
    if (state == S_DSTART) begin
      div_req.init_rem = num_mag;
      div_req.dividend = '0;
      div_req.divisor  = root_d;
      div_req.steps    = 7'(Q_FRAC);
    end else begin
      div_req.init_rem = '0;
      div_req.dividend = {10'd0, rabs, 22'd0};
      div_req.divisor  = {32'd0, before32};
      div_req.steps    = DIV_STEPS;
    end
  end

  // operand selection for the sum updates
  always_comb begin
    case (mstep)
      3'd0:    begin ma = old_x; mb = old_y; end
      3'd1:    begin ma = old_x; mb = old_x; end
      3'd2:    begin ma = old_y; mb = old_y; end
      3'd3:    begin ma = ret_x; mb = ret_y; end
      3'd4:    begin ma = ret_x; mb = ret_x; end
      default: begin ma = ret_y; mb = ret_y; end
    endcase
    prod_ext = 55'(prod48);
  end

  // operand selection for the variance terms
  always_comb begin
    case (vstep)
      2'd0:    begin vs = sum_cross;      sa = 32'(sum_returns); sb = 32'(sum_changes); end
      2'd1:    begin vs = sum_returns_sq; sa = 32'(sum_returns); sb = 32'(sum_returns); end
      default: begin vs = sum_changes_sq; sa = 32'(sum_changes); sb = 32'(sum_changes); end
    endcase
    vs_ext = 64'(vs);
  end

  assign mul_start = (state == S_MSTART);
  assign mul_a     = vx[63] ? 64'd0 : 64'(vx);
  assign mul_b     = vy[63] ? 64'd0 : 64'(vy);
  assign sq_start  = (state == S_QSTART);
  assign ram_re    = (state == S_RD);
  assign ram_we    = (state == S_WR);

  // sequencer and state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      reference_mode <= 1'b0;
      is_metal       <= 1'b0;
      previous_price <= '0;
      previous_ref   <= '0;
      have_previous  <= 1'b0;
      ring_pointer   <= '0;
      valid_count    <= '0;
      sum_returns    <= '0;
      sum_changes    <= '0;
      sum_cross      <= '0;
      sum_returns_sq <= '0;
      sum_changes_sq <= '0;
      mstep          <= '0;
      vstep          <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE:  reference_mode <= cfg_data[0];
          REG_METAL: is_metal       <= cfg_data[0];
          default:   ;
        endcase
      end
      // result leaves unless a new one is loaded in the same cycle
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (first_sample) begin
              ring_pointer   <= '0;
              valid_count    <= '0;
              sum_returns    <= '0;
              sum_changes    <= '0;
              sum_cross      <= '0;
              sum_returns_sq <= '0;
              sum_changes_sq <= '0;
              have_previous  <= 1'b0;
            end
            state <= pair ? S_XSTART : S_STATS;
          end
        end
        S_XSTART: state <= S_XWAIT;
        S_XWAIT: begin
          if (div_done) begin
            if (reference_mode) begin
              state <= S_RD;
            end else begin
              state <= S_YSTART;
            end
          end
        end
        S_YSTART: state <= S_YWAIT;
        S_YWAIT: begin
          if (div_done) begin
            state <= S_RD;
          end
        end
        S_RD: state <= S_RDW;
        S_RDW: begin
          mstep <= '0;
          state <= S_MAC;
        end
        S_MAC: begin
          // product of the previous step lands in its sum
          case (mstep)
            3'd1:    sum_cross      <= sum_cross - prod_ext;
            3'd2:    sum_returns_sq <= sum_returns_sq - prod_ext;
            3'd3:    sum_changes_sq <= sum_changes_sq - prod_ext;
            3'd4:    sum_cross      <= sum_cross + prod_ext;
            3'd5:    sum_returns_sq <= sum_returns_sq + prod_ext;
            3'd6:    sum_changes_sq <= sum_changes_sq + prod_ext;
            default: ;
          endcase
          mstep <= mstep + 3'd1;
          if (mstep == 3'd6) begin
            state <= S_WR;
          end
        end
        S_WR: begin
          sum_returns <= sum_returns + 31'(ret_x) - 31'(old_x);
          sum_changes <= sum_changes + 31'(ret_y) - 31'(old_y);
          ring_pointer <= (ring_pointer == PTR_W'(WINDOW - 1)) ? '0
                                                                 : ring_pointer + PTR_W'(1);
          if (!window_full) begin
            valid_count <= valid_count + CNT_W'(1);
          end
          state <= S_STATS;
        end
        S_STATS: begin
          previous_price <= cur_price;
          previous_ref   <= cur_ref;
          have_previous  <= 1'b1;
          vstep          <= '0;
          if (reference_mode && !is_metal) begin
            state <= S_OUT;
          end else if (!window_full) begin
            state <= S_OUT;
          end else begin
            state <= S_VAR;
          end
        end
        S_VAR: begin
          vstep <= vstep + 2'd1;
          if (vstep == 2'd3) begin
            state <= S_MSTART;
          end
        end
        S_MSTART: state <= S_MWAIT;
        S_MWAIT: begin
          if (mul_done) begin
            state <= S_QSTART;
          end
        end
        S_QSTART: state <= S_QWAIT;
        S_QWAIT: begin
          if (sq_done) begin
            if (sq_root == 64'd0 || num_mag >= sq_root) begin
              state <= S_OUT;
            end else begin
              state <= S_DSTART;
            end
          end
        end
        S_DSTART: state <= S_DWAIT;
        S_DWAIT: begin
          if (div_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cur_price <= price;
      cur_ref   <= ref_value;
    end
    if (state == S_XWAIT && div_done) begin
      ret_x <= sat_ret(div_q, rneg);
      ret_y <= ydiff;
    end
    if (state == S_YWAIT && div_done) begin
      ret_y <= sat_ret(div_q, rneg);
    end
    if (state == S_RDW) begin
      old_x <= window_full ? $signed(ram_rdata[2*RET_W-1:RET_W]) : '0;
      old_y <= window_full ? $signed(ram_rdata[RET_W-1:0]) : '0;
    end
    if (state == S_MAC) begin
      prod48 <= ma * mb;
    end
    if (state == S_VAR) begin
      vprod <= sa * sb;
      vnm   <= vs_ext * WINDOW;
      case (vstep)
        2'd1:    num_v <= vnm - vprod;
        2'd2:    vx    <= vnm - vprod;
        2'd3:    vy    <= vnm - vprod;
        default: ;
      endcase
    end
    if (state == S_STATS) begin
      corr_r   <= '0;
      status_r <= (reference_mode && !is_metal) ? ST_DISABLED : ST_NOT_FULL;
    end
    if (state == S_QWAIT && sq_done) begin
      root_d <= sq_root;
      if (sq_root == 64'd0) begin
        corr_r   <= '0;
        status_r <= ST_ZERO_VAR;
      end else begin
        corr_r   <= apply_sign(Q_ONE, num_v[63], !reference_mode && is_metal);
        status_r <= ST_OK;
      end
    end
    if (state == S_DWAIT && div_done) begin
      corr_r <= apply_sign(div_q[23:0], num_v[63], !reference_mode && is_metal);
    end
    if (state == S_OUT && (!out_valid || out_ready)) begin
      correlation <= corr_r;
      status      <= status_r;
    end
  end

  rrc_ram #(
    .WIDTH(2 * RET_W),
    .DEPTH(WINDOW)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ring_pointer),
    .wdata({ret_x, ret_y}),
    .re   (ram_re),
    .raddr(ring_pointer),
    .rdata(ram_rdata)
  );

  rrc_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .req     (div_req),
    .done    (div_done),
    .quotient(div_q)
  );

  rrc_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .done   (mul_done),
    .product(mul_p)
  );

  rrc_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (sq_start),
    .radicand(mul_p),
    .done    (sq_done),
    .root    (sq_root)
  );

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    valid_count <= CNT_W'(WINDOW))
    else $error("valid count beyond window");

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    ring_pointer < PTR_W'(WINDOW))
    else $error("ring pointer beyond window");

  a_zero_unless_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> correlation == 24'sd0)
    else $error("nonzero correlation with error status");

  a_corr_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (correlation <= Q_ONE) && (correlation >= -Q_ONE))
    else $error("correlation out of range");

endmodule

FILE: dv/rrc_checker.sv
module rrc_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [rrc_pkg::IDX_W-1:0] cfg_index,
  input  logic [0:0]         cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [31:0]        price,
  input  logic [22:0]        ref_value,
  input  logic               first_sample,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [23:0] correlation,
  input  logic [1:0]         status,
  output int                 mismatches,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import rrc_pkg::*;

  typedef struct packed {
    logic signed [23:0] corr;
    logic [1:0]         st;
  } corr_result_t;

  corr_result_t expected_q[$];

  // shadow of the block state
  logic [31:0]        last_price;
  logic [22:0]        last_ref;
  bit                 have_last;
  logic signed [23:0] ret_ring [WINDOW];
  logic signed [23:0] chg_ring [WINDOW];
  int                 ring_ptr;
  int                 pair_count;
  longint             s_x, s_y, s_xy, s_xx, s_yy;
  bit                 abs_mode;
  bit                 metal;

  assign pending = expected_q.size();

  // relative change in Q2.22, truncated toward zero and saturated
  function automatic logic signed [23:0] rel_change(logic [31:0] now, logic [31:0] was);
    longint d;
    longint q;
    d = (longint'(now) - longint'(was)) * 64'sd4194304;
    q = d / longint'(was);
    if (q > 64'sd8388607) q = 64'sd8388607;
    if (q < -64'sd8388608) q = -64'sd8388608;
    return q[23:0];
  endfunction

  // floor of the square root of a 128-bit value
  function automatic logic [63:0] root_floor(logic [127:0] v);
    logic [63:0]  res;
    logic [127:0] sq;
    res = '0;
    for (int b = 63; b >= 0; b--) begin
      sq = {64'b0, res | (64'd1 << b)};
      sq = sq * sq;
      if (sq <= v) res = res | (64'd1 << b);
    end
    return res;
  endfunction

  // advance the shadow state by one sample and form its result
  function automatic corr_result_t next_correlation(logic [31:0] p, logic [22:0] r, logic f);
    corr_result_t res;
    longint x, y, ox, oy, num, vx, vy;
    logic [127:0] prod;
    logic [63:0] den, mag, q;
    res.corr = '0;
    if (f) begin
      ring_ptr = 0; pair_count = 0;
      s_x = 0; s_y = 0; s_xy = 0; s_xx = 0; s_yy = 0;
      have_last = 0;
    end
    if (have_last && last_price != 0 && last_ref != 0) begin
      x = rel_change(p, last_price);
      if (abs_mode) y = longint'(r) - longint'(last_ref);
      else y = rel_change({9'b0, r}, {9'b0, last_ref});
      if (pair_count >= WINDOW) begin
        ox = ret_ring[ring_ptr];
        oy = chg_ring[ring_ptr];
        s_x -= ox; s_y -= oy; s_xy -= ox * oy; s_xx -= ox * ox; s_yy -= oy * oy;
      end else begin
        pair_count++;
      end
      ret_ring[ring_ptr] = x[23:0];
      chg_ring[ring_ptr] = y[23:0];
      s_x += x; s_y += y; s_xy += x * y; s_xx += x * x; s_yy += y * y;
      ring_ptr = (ring_ptr + 1 >= WINDOW) ? 0 : ring_ptr + 1;
    end
    last_price = p;
    last_ref = r;
    have_last = 1;

    if (abs_mode && !metal) begin
      res.st = ST_DISABLED;
    end else if (pair_count < WINDOW) begin
      res.st = ST_NOT_FULL;
    end else begin
      num = WINDOW * s_xy - s_x * s_y;
      vx = WINDOW * s_xx - s_x * s_x;
      vy = WINDOW * s_yy - s_y * s_y;
      if (vx < 0) vx = 0;
      if (vy < 0) vy = 0;
      prod = {64'b0, 64'(vx)} * {64'b0, 64'(vy)};
      den = root_floor(prod);
      if (den == 0) begin
        res.st = ST_ZERO_VAR;
      end else begin
        res.st = ST_OK;
        mag = (num < 0) ? 64'(-num) : 64'(num);
        if (mag >= den) q = 64'd4194304;
        else q = 64'(({64'b0, mag} << Q_FRAC) / {64'b0, den});
        res.corr = (num < 0) ? -q[23:0] : q[23:0];
        if (!abs_mode && metal) res.corr = -res.corr;
      end
    end
    return res;
  endfunction

  // watch configuration, input and output transfers
  always @(posedge clk) begin
    corr_result_t exp_r;
    if (rst) begin
      last_price = '0; last_ref = '0; have_last = 0;
      ring_ptr = 0; pair_count = 0;
      s_x = 0; s_y = 0; s_xy = 0; s_xx = 0; s_yy = 0;
      abs_mode = 0; metal = 0;
      mismatches = 0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_MODE) abs_mode = cfg_data[0];
        else if (cfg_index == REG_METAL) metal = cfg_data[0];
      end
      if (in_valid && in_ready) begin
        exp_r = next_correlation(price, ref_value, first_sample);
        expected_q = {expected_q, exp_r};
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: corr %0d status %0d", correlation, status);
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r.corr !== correlation || exp_r.st !== status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected corr %0d status %0d, got corr %0d status %0d",
                       exp_r.corr, exp_r.st, correlation, status);
          end
        end
      end
    end
  end

endmodule

FILE: dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rrc_pkg::*;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [IDX_W-1:0]   cfg_index;
  logic [0:0]         cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [31:0]        price;
  logic [22:0]        ref_value;
  logic               first_sample;
  logic               out_valid;
  logic               out_ready;
  logic signed [23:0] correlation;
  logic [1:0]         status;
  int                 mismatches;
  int                 pending;

  bit                 calm;
  bit                 hold_req;
  int                 held = 0;
  int                 samples_sent;
  logic [31:0]        walk_price;
  logic [22:0]        walk_ref;

  rolling_return_correlation_top dut (.*);

  rrc_checker checker_i (.*);

  // clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    longint cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 6000000) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // result side: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (hold_req && held < 3000) begin
      held <= held + 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 34);
    end
  end

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // one sample transfer; valid drops only when a gap is taken
  task automatic send_sample(input logic [31:0] p, input logic [22:0] r, input logic f);
    if (!calm && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 50);
    end
    in_valid <= 1'b1;
    price <= p;
    ref_value <= r;
    first_sample <= f;
    do @(posedge clk); while (!in_ready);
    samples_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // next point of a random walk, with rare jumps and zeros in wild mode
  task automatic step_walk(input int wild);
    logic [32:0] np;
    logic [23:0] nr;
    np = {1'b0, walk_price};
    nr = {1'b0, walk_ref};
    if (wild != 0 && $urandom_range(3) == 0) np = 33'($urandom);
    else if ($urandom_range(1))
      np = np + 33'(walk_price >> $urandom_range(12, 2)) + 33'($urandom_range(3));
    else
      np = np - 33'(walk_price >> $urandom_range(12, 2)) - 33'($urandom_range(3));
    if (np[32]) np = 33'h0ffffffff;
    if (wild != 0 && $urandom_range(3) == 0) nr = 24'($urandom_range(8388607));
    else if ($urandom_range(1))
      nr = nr + 24'(walk_ref >> $urandom_range(10, 2)) + 24'($urandom_range(3));
    else
      nr = nr - 24'(walk_ref >> $urandom_range(10, 2)) - 24'($urandom_range(3));
    if (nr[23]) nr = 24'h7fffff;
    if (wild != 0 && $urandom_range(15) == 0) np = 33'd0;
    if (wild != 0 && $urandom_range(15) == 0) nr = 24'd0;
    walk_price = np[31:0];
    walk_ref = nr[22:0];
  endtask

  // a series: random walk, flat, or wild
  task automatic run_series(input int len, input int kind);
    walk_price = $urandom_range(1) ? $urandom : $urandom_range(100000, 1000);
    walk_ref = 23'($urandom_range(8388607, 1));
    send_sample(walk_price, walk_ref, 1'b1);
    for (int k = 1; k < len; k++) begin
      if (kind != 1) step_walk(kind == 2);
      send_sample(walk_price, walk_ref, (kind == 2 && $urandom_range(63) == 0));
    end
  endtask

  task automatic run_phase(input int quota);
    int start;
    start = samples_sent;
    while (samples_sent - start < quota) begin
      case ($urandom_range(9))
        0:       run_series($urandom_range(95, 92), 1);
        1:       run_series($urandom_range(30, 5), 2);
        default: run_series($urandom_range(140, 92), 0);
      endcase
    end
    wait_idle();
  endtask

  // stimulus
  initial begin
    rst = 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_MODE;
    cfg_data <= 1'b0;
    in_valid <= 1'b0;
    price <= '0;
    ref_value <= '0;
    first_sample <= 1'b0;
    calm = 0;
    hold_req = 0;
    samples_sent = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners in relative mode
    write_reg(REG_MODE, 1'b0);
    write_reg(REG_METAL, 1'b0);
    send_sample(32'd0, 23'd0, 1'b0);
    send_sample(32'd100, 23'd100, 1'b0);
    send_sample(32'hffffffff, 23'h7fffff, 1'b0);
    send_sample(32'd1, 23'd1, 1'b0);
    send_sample(32'd0, 23'd5, 1'b0);
    send_sample(32'd7, 23'd0, 1'b0);
    send_sample(32'd7, 23'd9, 1'b0);
    send_sample(32'd8, 23'd3, 1'b0);
    send_sample(32'h80000000, 23'h400000, 1'b1);
    send_sample(32'h7fffffff, 23'h3fffff, 1'b0);
    send_sample(32'h55555555, 23'h2aaaaa, 1'b0);
    send_sample(32'haaaaaaaa, 23'h555555, 1'b0);
    wait_idle();
    // absolute mode, disabled then enabled
    write_reg(REG_MODE, 1'b1);
    send_sample(32'd50, 23'd1, 1'b1);
    send_sample(32'd60, 23'h7fffff, 1'b0);
    send_sample(32'd70, 23'd1, 1'b0);
    wait_idle();
    write_reg(REG_METAL, 1'b1);
    send_sample(32'd50, 23'd1, 1'b1);
    send_sample(32'd60, 23'h7fffff, 1'b0);
    send_sample(32'd70, 23'd1, 1'b0);
    wait_idle();

    // random phases over all settings
    write_reg(REG_MODE, 1'b0);
    write_reg(REG_METAL, 1'b0);
    hold_req = 1;
    run_phase(500);
    write_reg(REG_METAL, 1'b1);
    calm = 1;
    run_phase(250);
    calm = 0;
    run_phase(250);
    write_reg(REG_MODE, 1'b1);
    run_phase(500);
    write_reg(REG_METAL, 1'b0);
    run_phase(250);
    write_reg(REG_METAL, 1'b1);
    run_phase(250);

    wait_idle();
    repeat (400) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
